// ----- src/kmst_pkg.sv -----
// shared sizes, types and state codes for the minimum spanning tree block
// no dependencies
package kmst_pkg;
  localparam int MAX_VERTICES = 16;
  localparam int MAX_EDGES = 64;
  localparam int VW = $clog2(MAX_VERTICES);
  localparam int EW = $clog2(MAX_EDGES);
  localparam int WW = 16;
  localparam int EDGE_W = 2 * VW + WW;
  localparam int KEY_W = WW + EW;

  typedef struct packed {
    logic          init;
    logic          merge;
    logic [VW-1:0] ra;
    logic [VW-1:0] rb;
  } uf_cmd_t;

  typedef enum logic [4:0] {
    S_LOAD  = 5'b00001,
    S_SCAN  = 5'b00010,
    S_FINDA = 5'b00100,
    S_FINDB = 5'b01000,
    S_EMIT  = 5'b10000
  } state_t;
endpackage

// ----- src/kmst_ram.sv -----
// generic single write port ram with registered read
// no dependencies
module kmst_ram #(
  parameter int W = 8,
  parameter int D = 16
) (
  input  logic                 clk,
  input  logic                 we,
  input  logic [$clog2(D)-1:0] waddr,
  input  logic [W-1:0]         wdata,
  input  logic [$clog2(D)-1:0] raddr,
  output logic [W-1:0]         rdata
);
  logic [W-1:0] mem [D];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

// ----- src/kmst_uf.sv -----
// union-find parent and rank storage, one parent lookup per cycle
// depends on kmst_pkg
module kmst_uf import kmst_pkg::*; (
  input  logic          clk,
  input  logic          rst_n,
  input  uf_cmd_t       cmd,
  input  logic [VW-1:0] look_v,
  output logic [VW-1:0] look_parent
);
  logic [VW-1:0] parent_r [MAX_VERTICES];
  logic [2:0]    rank_r [MAX_VERTICES];

  assign look_parent = parent_r[look_v];

  always_ff @(posedge clk) begin
    if (!rst_n || cmd.init) begin
      for (int v = 0; v < MAX_VERTICES; v++) begin
        parent_r[v] <= VW'(v);
        rank_r[v] <= '0;
      end
    end else if (cmd.merge) begin
      if (rank_r[cmd.ra] < rank_r[cmd.rb]) begin
        parent_r[cmd.ra] <= cmd.rb;
      end else if (rank_r[cmd.ra] > rank_r[cmd.rb]) begin
        parent_r[cmd.rb] <= cmd.ra;
      end else begin
        parent_r[cmd.rb] <= cmd.ra;
        rank_r[cmd.ra] <= rank_r[cmd.ra] + 3'd1;
      end
    end
  end
endmodule

// ----- src/kruskal_minimum_spanning_tree.sv -----
// top level: edge loading, minimum search sequencer, union-find walk, result output
// depends on kmst_pkg, kmst_ram, kmst_uf
//
// channel  dir  tdata / payload                     marks
// in_      in   src[3:0] dst[7:4] weight[23:8]      tlast = final edge
// out_     out  src[3:0] dst[7:4] weight[23:8]      tuser no_edge,spanning,dropped; tlast
// cfg_     in   vertex_count[4:0]                   always ready
//
// edges load one per cycle while in the load state; after the final edge every stored edge
// taken in sorted order costs one scan of all stored edges through the ram read port for
// the next smallest key and, if both ends are in range, a walk of both parent chains, which
// union by rank keeps at 4 links or fewer; reset is synchronous and needs no clearing pass;
// input stalls during a run and output stalls simply hold the current result
module kruskal_minimum_spanning_tree import kmst_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_tvalid,
  output logic              in_tready,
  input  logic [23:0]       in_tdata,  // src_vertex, dst_vertex, edge_weight
  input  logic              in_tlast,
  output logic              out_tvalid,
  input  logic              out_tready,
  output logic [23:0]       out_tdata, // tree_src, tree_dst, tree_weight
  output logic [2:0]        out_tuser, // no_edge, spanning, dropped
  output logic              out_tlast,
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  logic [4:0]        cfg_data
);
  state_t state_r, state_nxt;
  logic [4:0]        vc_r;
  logic [VW:0]       vce_r, vce_nxt, vce_cfg;
  logic [EW:0]       total_r, total_nxt, scan_idx_r, scan_idx_nxt;
  logic              ovf_r, ovf_nxt, rd_valid_r, rd_valid_nxt;
  logic [EW-1:0]     rd_idx_r, rd_idx_nxt;
  logic              have_last_r, have_last_nxt, have_best_r, have_best_nxt;
  logic [KEY_W-1:0]  last_key_r, last_key_nxt, best_key_r, best_key_nxt, key;
  logic [EDGE_W-1:0] best_edge_r, best_edge_nxt, rdata, wdata;
  logic [VW-1:0]     cur_r, cur_nxt, ra_r, ra_nxt, cnt_r, cnt_nxt;
  logic [VW-1:0]     out_idx_r, out_idx_nxt, parent, a_v, b_v;
  logic [EDGE_W-1:0] acc_r [MAX_VERTICES-1];
  logic              acc_we, ram_we, in_xfer, out_xfer, cand, marker, last;
  uf_cmd_t           uf_cmd;

  assign cfg_ready = 1'b1;
  assign in_tready = (state_r == S_LOAD);
  assign in_xfer = in_tvalid && in_tready;
  assign out_tvalid = (state_r == S_EMIT);
  assign out_xfer = out_tvalid && out_tready;

  assign vce_cfg = (vc_r == 5'd0) ? (VW+1)'(1) :
                   ({1'b0, vc_r} > 6'(MAX_VERTICES)) ? (VW+1)'(MAX_VERTICES) :
                   (VW+1)'(vc_r);

  assign wdata = {in_tdata[3:0], in_tdata[7:4], in_tdata[23:8]};
  assign ram_we = in_xfer && (total_r < (EW+1)'(MAX_EDGES));

  kmst_ram #(.W(EDGE_W), .D(MAX_EDGES)) u_store (
    .clk(clk), .we(ram_we), .waddr(total_r[EW-1:0]), .wdata(wdata),
    .raddr(scan_idx_r[EW-1:0]), .rdata(rdata)
  );

  kmst_uf u_uf (.clk(clk), .rst_n(rst_n), .cmd(uf_cmd), .look_v(cur_r), .look_parent(parent));

  assign key = {~rdata[WW-1], rdata[WW-2:0], rd_idx_r};
  assign cand = rd_valid_r && (!have_last_r || key > last_key_r) &&
                (!have_best_r || key < best_key_r);
  assign a_v = best_edge_r[EDGE_W-1 -: VW];
  assign b_v = best_edge_r[EDGE_W-VW-1 -: VW];

  assign marker = (cnt_r == '0);
  assign last = marker || (out_idx_r == cnt_r - VW'(1));
  assign out_tdata = marker ? '0 :
      {acc_r[out_idx_r][WW-1:0], acc_r[out_idx_r][EDGE_W-VW-1 -: VW],
       acc_r[out_idx_r][EDGE_W-1 -: VW]};
  assign out_tuser = {ovf_r,
                      marker ? (vce_r == (VW+1)'(1)) : ({1'b0, cnt_r} == vce_r - (VW+1)'(1)),
                      marker};
  assign out_tlast = last;

  always_comb begin
    state_nxt = state_r;
    total_nxt = total_r;
    ovf_nxt = ovf_r;
    vce_nxt = vce_r;
    scan_idx_nxt = scan_idx_r;
    rd_valid_nxt = 1'b0;
    rd_idx_nxt = rd_idx_r;
    have_last_nxt = have_last_r;
    last_key_nxt = last_key_r;
    have_best_nxt = have_best_r;
    best_key_nxt = best_key_r;
    best_edge_nxt = best_edge_r;
    cur_nxt = cur_r;
    ra_nxt = ra_r;
    cnt_nxt = cnt_r;
    out_idx_nxt = out_idx_r;
    acc_we = 1'b0;
    uf_cmd = '0;
    uf_cmd.ra = ra_r;
    uf_cmd.rb = cur_r;
    unique case (state_r)
      S_LOAD: begin
        if (in_xfer) begin
          if (ram_we) total_nxt = total_r + (EW+1)'(1);
          else ovf_nxt = 1'b1;
          if (in_tlast) begin
            uf_cmd.init = 1'b1;
            vce_nxt = vce_cfg;
            cnt_nxt = '0;
            out_idx_nxt = '0;
            scan_idx_nxt = '0;
            have_last_nxt = 1'b0;
            have_best_nxt = 1'b0;
            state_nxt = (vce_cfg == (VW+1)'(1)) ? S_EMIT : S_SCAN;
          end
        end
      end
      S_SCAN: begin
        if (cand) begin
          have_best_nxt = 1'b1;
          best_key_nxt = key;
          best_edge_nxt = rdata;
        end
        if (scan_idx_r < total_r) begin
          rd_valid_nxt = 1'b1;
          rd_idx_nxt = scan_idx_r[EW-1:0];
          scan_idx_nxt = scan_idx_r + (EW+1)'(1);
        end else if (!rd_valid_r) begin
          if (!have_best_r) begin
            state_nxt = S_EMIT;
          end else begin
            have_last_nxt = 1'b1;
            last_key_nxt = best_key_r;
            have_best_nxt = 1'b0;
            scan_idx_nxt = '0;
            if ({1'b0, a_v} >= vce_r || {1'b0, b_v} >= vce_r) begin
              state_nxt = S_SCAN;
            end else begin
              cur_nxt = a_v;
              state_nxt = S_FINDA;
            end
          end
        end
      end
      S_FINDA: begin
        if (parent == cur_r) begin
          ra_nxt = cur_r;
          cur_nxt = b_v;
          state_nxt = S_FINDB;
        end else begin
          cur_nxt = parent;
        end
      end
      S_FINDB: begin
        if (parent == cur_r) begin
          state_nxt = S_SCAN;
          if (ra_r != cur_r) begin
            acc_we = 1'b1;
            uf_cmd.merge = 1'b1;
            cnt_nxt = cnt_r + VW'(1);
            if ({1'b0, cnt_r} + (VW+1)'(1) == vce_r - (VW+1)'(1)) state_nxt = S_EMIT;
          end
        end else begin
          cur_nxt = parent;
        end
      end
      S_EMIT: begin
        if (out_xfer) begin
          if (last) begin
            total_nxt = '0;
            ovf_nxt = 1'b0;
            state_nxt = S_LOAD;
          end else begin
            out_idx_nxt = out_idx_r + VW'(1);
          end
        end
      end
      default: state_nxt = S_LOAD;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_LOAD;
      vc_r <= 5'd16;
      total_r <= '0;
      ovf_r <= 1'b0;
      rd_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (cfg_valid && cfg_ready) vc_r <= cfg_data;
      total_r <= total_nxt;
      ovf_r <= ovf_nxt;
      rd_valid_r <= rd_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    vce_r <= vce_nxt;
    scan_idx_r <= scan_idx_nxt;
    rd_idx_r <= rd_idx_nxt;
    have_last_r <= have_last_nxt;
    last_key_r <= last_key_nxt;
    have_best_r <= have_best_nxt;
    best_key_r <= best_key_nxt;
    best_edge_r <= best_edge_nxt;
    cur_r <= cur_nxt;
    ra_r <= ra_nxt;
    cnt_r <= cnt_nxt;
    out_idx_r <= out_idx_nxt;
    if (acc_we) acc_r[cnt_r] <= best_edge_r;
  end

  a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
    !(in_tready && out_tvalid)) else $error("input and output both open");
  a_total_cap: assert property (@(posedge clk) disable iff (!rst_n)
    total_r <= (EW+1)'(MAX_EDGES)) else $error("edge count past capacity");
  a_done_clears: assert property (@(posedge clk) disable iff (!rst_n)
    out_xfer && out_tlast |=> total_r == '0 && !ovf_r) else $error("run end not cleared");
  a_no_read_in_emit: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_EMIT |-> !rd_valid_r) else $error("scan read pending at output");
endmodule

// ----- tb/kmst_checker.sv -----
// checker for the minimum spanning tree block: watches the edge, config and tree channels,
// predicts the tree edges of each graph and compares every output transfer
// depends on kmst_pkg
module kmst_checker import kmst_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  input  logic        in_tready,
  input  logic [23:0] in_tdata,
  input  logic        in_tlast,
  input  logic        out_tvalid,
  input  logic        out_tready,
  input  logic [23:0] out_tdata,
  input  logic [2:0]  out_tuser,
  input  logic        out_tlast,
  input  logic        cfg_valid,
  input  logic        cfg_ready,
  input  logic [4:0]  cfg_data,
  output int          fail_count,
  output int          pending
);
  typedef struct packed {
    logic [3:0]  src;
    logic [3:0]  dst;
    logic [15:0] weight;
    logic        no_edge;
    logic        spanning;
    logic        dropped;
    logic        last;
  } tree_edge_t;

  tree_edge_t tree_q[$];
  logic [23:0] edges[MAX_EDGES];
  int          edge_cnt;
  logic        lost;
  logic [4:0]  vcount;
  int          parent[MAX_VERTICES];
  int          rnk[MAX_VERTICES];

  assign pending = tree_q.size();

  function automatic int find_root(int v);
    int r;
    int nx;
    r = v;
    while (parent[r] != r) r = parent[r];
    while (parent[v] != r) begin
      nx = parent[v];
      parent[v] = r;
      v = nx;
    end
    return r;
  endfunction

  task automatic build_tree();
    logic [23:0] srt[MAX_EDGES];
    logic [23:0] e;
    tree_edge_t  t;
    int vc, j, a, b, ra, rb, acc, first;
    vc = (vcount < 1) ? 1 : (vcount > MAX_VERTICES) ? MAX_VERTICES : int'(vcount);
    for (int i = 0; i < edge_cnt; i++) begin
      e = edges[i];
      j = i;
      while (j > 0 && $signed(srt[j-1][23:8]) > $signed(e[23:8])) begin
        srt[j] = srt[j-1];
        j--;
      end
      srt[j] = e;
    end
    for (int v = 0; v < MAX_VERTICES; v++) begin
      parent[v] = v;
      rnk[v] = 0;
    end
    acc = 0;
    first = tree_q.size();
    for (int i = 0; i < edge_cnt && acc < vc - 1; i++) begin
      a = srt[i][3:0];
      b = srt[i][7:4];
      if (a >= vc || b >= vc) continue;
      ra = find_root(a);
      rb = find_root(b);
      if (ra != rb) begin
        t = '{src: a[3:0], dst: b[3:0], weight: srt[i][23:8], no_edge: 0,
              spanning: 0, dropped: lost, last: 0};
        tree_q.push_back(t);
        acc++;
        if (rnk[ra] < rnk[rb]) parent[ra] = rb;
        else if (rnk[ra] > rnk[rb]) parent[rb] = ra;
        else begin
          parent[rb] = ra;
          rnk[ra]++;
        end
      end
    end
    if (acc == 0) begin
      t = '{src: 0, dst: 0, weight: 0, no_edge: 1, spanning: (vc == 1), dropped: lost,
            last: 1};
      tree_q.push_back(t);
    end else begin
      for (int i = first; i < tree_q.size(); i++) tree_q[i].spanning = (acc == vc - 1);
      tree_q[tree_q.size()-1].last = 1;
    end
    edge_cnt = 0;
    lost = 0;
  endtask

  always @(posedge clk) begin
    tree_edge_t got;
    tree_edge_t exp_t;
    if (!rst_n) begin
      vcount <= 5'd16;
      edge_cnt = 0;
      lost = 0;
      fail_count <= 0;
    end else begin
      if (cfg_valid && cfg_ready) vcount <= cfg_data;
      if (out_tvalid && out_tready) begin
        got = {out_tdata[3:0], out_tdata[7:4], out_tdata[23:8],
               out_tuser[0], out_tuser[1], out_tuser[2], out_tlast};
        if (tree_q.size() == 0) begin
          if (fail_count < 10) $display("unexpected tree transfer %h", got);
          fail_count <= fail_count + 1;
        end else begin
          exp_t = tree_q.pop_front();
          if (got !== exp_t) begin
            if (fail_count < 10) $display("mismatch: expected %h actual %h", exp_t, got);
            fail_count <= fail_count + 1;
          end
        end
      end
      if (in_tvalid && in_tready) begin
        if (edge_cnt < MAX_EDGES) edges[edge_cnt++] = in_tdata;
        else lost = 1;
        if (in_tlast) build_tree();
      end
    end
  end
endmodule

// ----- tb/tb_kruskal_minimum_spanning_tree.sv -----
// testbench top for the minimum spanning tree block: drives graphs and vertex counts,
// random gaps on both sides, and reports the verdict
// depends on kmst_pkg, kruskal_minimum_spanning_tree, kmst_checker
module tb_kruskal_minimum_spanning_tree;
  import kmst_pkg::*;

  logic        clk = 0;
  logic        rst_n = 0;
  logic        in_tvalid = 0;
  logic        in_tready;
  logic [23:0] in_tdata = 0;
  logic        in_tlast = 0;
  logic        out_tvalid;
  logic        out_tready = 0;
  logic [23:0] out_tdata;
  logic [2:0]  out_tuser;
  logic        out_tlast;
  logic        cfg_valid = 0;
  logic        cfg_ready;
  logic [4:0]  cfg_data = 0;
  int          fail_count;
  int          pending;
  bit          calm = 0;
  int          idle_cycles = 0;
  int          sent = 0;

  always #5 clk = ~clk;

  kruskal_minimum_spanning_tree u_dut (.*);
  kmst_checker u_chk (.*);

  // watchdog on cycles with no transfer
  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready) || (cfg_valid && cfg_ready))
      idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles > 20000) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  // result side stalls
  initial begin
    int n;
    forever begin
      @(posedge clk);
      if (!calm && $urandom_range(3) == 0) begin
        n = $urandom_range(8, 1);
        out_tready <= 0;
        repeat (n) @(posedge clk);
      end
      out_tready <= 1;
    end
  end

  task automatic send_edge(logic [3:0] s, logic [3:0] d, logic [15:0] w, logic fin);
    if (!calm && $urandom_range(3) == 0) begin
      in_tvalid <= 0;
      repeat ($urandom_range(8, 1)) @(posedge clk);
    end
    in_tvalid <= 1;
    in_tdata  <= {w, d, s};
    in_tlast  <= fin;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    sent++;
    if (fin) begin
      in_tvalid <= 0;
      @(posedge clk);
    end
  endtask

  task automatic set_vertices(logic [4:0] v);
    while (pending != 0) @(posedge clk);
    repeat (600) @(posedge clk);
    cfg_valid <= 1;
    cfg_data  <= v;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 0;
  endtask

  task automatic random_graph(int n, int vmax);
    for (int i = 0; i < n; i++)
      send_edge(4'($urandom_range(vmax)), 4'($urandom_range(vmax)),
                ($urandom_range(3) == 0) ? 16'($urandom) : 16'($urandom_range(40)),
                i == n - 1);
  endtask

  initial begin
    repeat (6) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);
    // reset vertex count 16: extreme weights, ties, self loop
    send_edge(4'd0, 4'd15, 16'h8000, 0);
    send_edge(4'd15, 4'd15, 16'h7fff, 0);
    send_edge(4'd3, 4'd4, 16'h0005, 0);
    send_edge(4'd4, 4'd5, 16'h0005, 0);
    send_edge(4'd3, 4'd5, 16'h0005, 1);
    set_vertices(5'd1);
    send_edge(4'd0, 4'd1, 16'h0001, 1);
    set_vertices(5'd0);
    send_edge(4'd0, 4'd0, 16'hffff, 1);
    set_vertices(5'd31);
    send_edge(4'd2, 4'd9, 16'h1234, 0);
    send_edge(4'd9, 4'd2, 16'h1234, 1);
    set_vertices(5'd3);
    send_edge(4'd1, 4'd2, 16'h0003, 0);
    send_edge(4'd0, 4'd7, 16'h0000, 0);
    send_edge(4'd0, 4'd1, 16'hfffe, 1);
    set_vertices(5'd2);
    send_edge(4'd5, 4'd6, 16'h0001, 1);
    // overflow of the edge store
    set_vertices(5'd16);
    random_graph(70, 15);
    while (sent < 160) begin
      set_vertices(5'($urandom_range(17)));
      random_graph($urandom_range(12, 2), ($urandom_range(1) == 0) ? 15 : 7);
    end
    set_vertices(5'd8);
    calm = 1;
    random_graph(12, 7);
    random_graph(10, 7);
    while (pending != 0) @(posedge clk);
    repeat (600) @(posedge clk);
    if (fail_count == 0) $display("TB_OK");
    else $display("TB_ERROR");
    $finish;
  end
endmodule

// ----- files.f -----
src/kmst_pkg.sv
src/kmst_ram.sv
src/kmst_uf.sv
src/kruskal_minimum_spanning_tree.sv
tb/kmst_checker.sv
tb/tb_kruskal_minimum_spanning_tree.sv
